/* rtl/thread_capture_table_unit_assert.svh */
// Assertion macros used by the thread capture table top module.
`ifndef THREAD_CAPTURE_TABLE_UNIT_ASSERT_SVH
`define THREAD_CAPTURE_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thread capture table check failed");
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thread capture table check failed");
`else
`define TCT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/tct_pkg.sv */
package tct_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam logic [31:0] DEFAULT_HOVER_RESET = 32'd400;
  localparam logic [31:0] HOVER_USE_DEFAULT = 32'hFFFF_FFFF;
  localparam logic [1:0] HOVER_LEAVE_BOTH = 2'b11;

  typedef enum logic [2:0] {
    REQ_SET_CAPTURE   = 3'd0,
    REQ_RELEASE       = 3'd1,
    REQ_GET           = 3'd2,
    REQ_SET_FLAGS     = 3'd3,
    REQ_TRACK         = 3'd4,
    REQ_GET_WINDOW    = 3'd5,
    REQ_POSITION      = 3'd6,
    REQ_RELEASE_MATCH = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOSPACE  = 2'd1,
    STAT_NOTFOUND = 2'd2
  } stat_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [63:0] last_pos;
    logic [31:0] hover_time;
    logic [1:0]  hover_leave;
    logic [63:0] track_window;
    logic [31:0] flags;
    logic [63:0] capture_window;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic lookup;
    logic execute;
  } cmd_t;

endpackage

/* rtl/tct_in_if.sv */
interface tct_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [31:0]        thread_id;
  logic [63:0]        window;
  logic [31:0]        capture_flags;
  logic [31:0]        hover_time;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;

  modport source (output valid, req_type, thread_id, window, capture_flags, hover_time,
                  pos_x, pos_y, input ready);
  modport sink (input valid, req_type, thread_id, window, capture_flags, hover_time,
                pos_x, pos_y, output ready);
endinterface

/* rtl/tct_out_if.sv */
interface tct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] window_out;
  logic [31:0] thread_id_out;

  modport source (output valid, status, window_out, thread_id_out, input ready);
  modport sink (input valid, status, window_out, thread_id_out, output ready);
endinterface

/* rtl/thread_capture_table_unit.sv */
// Per-thread capture table with one request beat in and one result beat out. A request is
// accepted when the block is idle and the result register is empty or being emptied; the
// thread lookup is a parallel compare over all valid entries in the accept cycle, and the
// entry memory is read then and written back in the following cycle, so a new request is
// not accepted until the previous one has left the execute state.
// Set-capture, set-flags and track requests allocate the lowest free entry for an unknown
// thread, and entries are never freed. The default hover time register resets to 400 and
// should be written only while no request is in flight.
module thread_capture_table_unit #(
  parameter int TABLE_ENTRIES = tct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tct_in_if.sink      in_chan,
  tct_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import tct_pkg::*;

  cmd_t cmd;

  tct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  tct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_type      (in_chan.req_type),
    .thread_id     (in_chan.thread_id),
    .window        (in_chan.window),
    .capture_flags (in_chan.capture_flags),
    .hover_time    (in_chan.hover_time),
    .pos_x         (in_chan.pos_x),
    .pos_y         (in_chan.pos_y),
    .status        (out_chan.status),
    .window_out    (out_chan.window_out),
    .thread_id_out (out_chan.thread_id_out)
  );

`include "thread_capture_table_unit_assert.svh"

  `TCT_ASSERT_NEXT(a_accept_then_exec, clk, rst_n, cmd.lookup, cmd.execute)
  `TCT_ASSERT_NEXT(a_exec_then_result, clk, rst_n, cmd.execute, out_chan.valid)
  `TCT_ASSERT_SAME(a_exec_blocks_input, clk, rst_n, cmd.execute, !in_chan.ready)
  `TCT_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, out_chan.valid && !out_chan.ready,
                   !in_chan.ready)

endmodule

/* rtl/tct_ram.sv */
module tct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tct_ctrl.sv */
module tct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tct_pkg::cmd_t cmd
);
  import tct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = rst_n && (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.lookup  = accept;
  assign cmd.execute = (state_r == ST_EXEC);
  assign out_valid   = out_valid_r;

endmodule

/* rtl/tct_dp.sv */
module tct_dp #(
  parameter int TABLE_ENTRIES = tct_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tct_pkg::cmd_t      cmd,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic [2:0]         req_type,
  input  logic [31:0]        thread_id,
  input  logic [63:0]        window,
  input  logic [31:0]        capture_flags,
  input  logic [31:0]        hover_time,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  output logic [1:0]         status,
  output logic [63:0]        window_out,
  output logic [31:0]        thread_id_out
);
  import tct_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]              thread_r [TABLE_ENTRIES];
  logic [31:0]              dflt_hover_r;

  req_t              req_r;
  logic [31:0]       tid_r;
  logic [63:0]       win_r;
  logic [31:0]       flags_r;
  logic [31:0]       hover_r;
  logic [31:0]       posx_r;
  logic [31:0]       posy_r;
  logic [IDX_W-1:0]  idx_r;
  logic              ok_r;
  logic              alloc_r;

  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         look_idx;
  logic                     found;
  logic                     has_free;
  logic                     alloc_req;
  logic                     alloc;

  entry_t      rd_entry;
  entry_t      base;
  entry_t      wr_entry;
  logic        wr_en;
  logic [1:0]  stat_c;
  logic [63:0] wout_c;
  logic [31:0] tout_c;
  logic [1:0]  status_r;
  logic [63:0] wout_r;
  logic [31:0] tout_r;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (thread_r[i] == thread_id);
    end
  end

  // Lowest set bit wins in both searches.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign found     = |hit_vec;
  assign has_free  = ~&valid_r;
  assign alloc_req = (req_t'(req_type) inside {REQ_SET_CAPTURE, REQ_SET_FLAGS, REQ_TRACK});
  assign alloc     = !found && alloc_req && has_free;
  assign look_idx  = found ? hit_idx : free_idx;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.lookup && alloc) begin
      valid_nxt[look_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      dflt_hover_r <= DEFAULT_HOVER_RESET;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        dflt_hover_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      if (alloc) begin
        thread_r[look_idx] <= thread_id;
      end
      req_r   <= req_t'(req_type);
      tid_r   <= thread_id;
      win_r   <= window;
      flags_r <= capture_flags;
      hover_r <= hover_time;
      posx_r  <= pos_x;
      posy_r  <= pos_y;
      idx_r   <= look_idx;
      ok_r    <= found || alloc;
      alloc_r <= alloc;
    end
  end

  tct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_r),
    .wdata (wr_entry),
    .re    (cmd.lookup),
    .raddr (look_idx),
    .rdata (rd_entry)
  );

  // A freshly allocated entry starts from all zeros.
  assign base = alloc_r ? '0 : rd_entry;

  always_comb begin
    wr_entry = base;
    stat_c   = STAT_OK;
    wout_c   = '0;
    tout_c   = '0;
    case (req_r)
      REQ_SET_CAPTURE: begin
        if (!ok_r) begin
          stat_c = STAT_NOSPACE;
        end
        wr_entry.capture_window = win_r;
      end
      REQ_RELEASE: begin
        if (!ok_r) begin
          stat_c = STAT_NOTFOUND;
        end
        wr_entry.capture_window = '0;
      end
      REQ_GET: begin
        if (ok_r) begin
          wout_c = base.capture_window;
        end
      end
      REQ_SET_FLAGS: begin
        if (!ok_r) begin
          stat_c = STAT_NOSPACE;
        end
        wr_entry.capture_window = win_r;
        wr_entry.flags          = flags_r;
      end
      REQ_TRACK: begin
        if (!ok_r) begin
          stat_c = STAT_NOSPACE;
        end
        wr_entry.track_window = win_r;
        wr_entry.hover_leave  = HOVER_LEAVE_BOTH;
        wr_entry.hover_time   = (hover_r == HOVER_USE_DEFAULT) ? dflt_hover_r : hover_r;
      end
      REQ_GET_WINDOW: begin
        if (ok_r && (base.capture_window != '0)) begin
          wout_c = base.capture_window;
          tout_c = tid_r;
        end else begin
          stat_c = STAT_NOTFOUND;
        end
      end
      REQ_POSITION: begin
        wr_entry.last_pos = {posy_r, posx_r};
      end
      REQ_RELEASE_MATCH: begin
        if (ok_r && (base.capture_window == win_r)) begin
          wr_entry.capture_window = '0;
        end else begin
          stat_c = STAT_NOTFOUND;
        end
      end
      default: begin
        stat_c = STAT_NOTFOUND;
      end
    endcase
  end

  assign wr_en = cmd.execute && ok_r;

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status_r <= stat_c;
      wout_r   <= wout_c;
      tout_r   <= tout_c;
    end
  end

  assign status        = status_r;
  assign window_out    = wout_r;
  assign thread_id_out = tout_r;

endmodule
